// ----- rtl/core/lpse_pkg.sv -----
// ----------------------------------------------------------------------------
// LED pulse SPI symbol encoder package
// Shared constants, payload types and the 6-bit symbol encoding.
// ----------------------------------------------------------------------------
package lpse_pkg;

    localparam int MAX_PIXELS   = 1024;
    localparam int PRE_GUARD    = 4;
    localparam int POST_GUARD   = 16;

    localparam int COLOR_W      = 8;
    localparam int LEN_W        = 11;
    localparam int POS_W        = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = LEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_CHAN_ORDER       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_FRAME = CFG_IDX_W'(1);

    localparam logic [5:0] SYM_ONE  = 6'h38;
    localparam logic [5:0] SYM_ZERO = 6'h20;

    localparam int BYTES_PER_CHANNEL = 6;
    localparam int DATA_BYTES        = 3 * BYTES_PER_CHANNEL;
    localparam int MAX_JOB_BYTES     = PRE_GUARD + DATA_BYTES + POST_GUARD;
    localparam int STEP_W            = $clog2(MAX_JOB_BYTES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [COLOR_W-1:0] ch0;
        logic [COLOR_W-1:0] ch1;
        logic [COLOR_W-1:0] ch2;
        logic               pre;
        logic               post;
    } t_job;

    function automatic logic [7:0] sym_byte(input logic [COLOR_W-1:0] value,
                                            input logic [2:0]         idx);
        logic [6*COLOR_W-1:0] packed_sym;
        logic [2:0]           slot;
        for (int b = 0; b < COLOR_W; b++) begin
            packed_sym[6*b +: 6] = value[b] ? SYM_ONE : SYM_ZERO;
        end
        slot = 3'(BYTES_PER_CHANNEL - 1) - idx;
        return packed_sym[8*slot +: 8];
    endfunction

endpackage

// ----- rtl/core/lpse_if.sv -----
// ----------------------------------------------------------------------------
// LED pulse SPI symbol encoder interfaces
// Pixel, encoded byte and register write channels.
// ----------------------------------------------------------------------------
interface lpse_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [lpse_pkg::COLOR_W-1:0] red;
    logic [lpse_pkg::COLOR_W-1:0] green;
    logic [lpse_pkg::COLOR_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface lpse_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_pixel;
    logic       frame_end;

    modport source (output valid, output out_byte, output last_of_pixel,
                    output frame_end, input ready);
    modport sink   (input valid, input out_byte, input last_of_pixel,
                    input frame_end, output ready);
endinterface

interface lpse_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lpse_pkg::CFG_IDX_W-1:0]  index;
    logic [lpse_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/led_pulse_spi_symbol_encoder.sv -----
// ----------------------------------------------------------------------------
// LED pulse SPI symbol encoder
// Turns RGB pixels into the 6-bit-per-bit SPI byte stream of an LED strip.
//
//   channel   dir   word                                 handshake
//   i_pixel   in    red, green, blue                     valid/ready
//   i_cfg     in    index, data (register write)         valid/ready, ready tied high
//   o_byte    out   out_byte, last_of_pixel, frame_end   valid/ready
//
// The serializer sends one word per cycle unless the output stalls: 18 bytes
// per pixel, plus 4 guard bytes before the first pixel of a frame and 16 after
// its last. The byte serializer sets that rate. A two-entry job queue lets the
// front end take the next pixel while the current one is still being sent.
// Reset clears the pixel position, the queue and the output valid; the channel
// order and the frame length reset to 1. Output stalls hold the serializer in place.
// ----------------------------------------------------------------------------
module led_pulse_spi_symbol_encoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpse_pixel_if.sink   i_pixel,
    lpse_cfg_if.sink     i_cfg,
    lpse_byte_if.source  o_byte
);
    import lpse_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_qvalid;
    t_job w_in_job;
    t_job w_head_job;

    lpse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pixel (i_pixel),
        .i_cfg   (i_cfg),
        .o_push  (w_push),
        .o_job   (w_in_job),
        .i_full  (w_full)
    );

    lpse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_head_job)
    );

    lpse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_job   (w_head_job),
        .o_pop   (w_pop),
        .o_byte  (o_byte)
    );

endmodule

// ----- rtl/core/lpse_front.sv -----
// ----------------------------------------------------------------------------
// LED pulse SPI symbol encoder front end
// Holds the registers, reorders channels and tags frame guards per pixel.
// ----------------------------------------------------------------------------
module lpse_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lpse_pixel_if.sink           i_pixel,
    lpse_cfg_if.sink             i_cfg,
    output logic                 o_push,
    output lpse_pkg::t_job       o_job,
    input  logic                 i_full
);
    import lpse_pkg::*;

    logic             r_grb_first,   n_grb_first;
    logic [LEN_W-1:0] r_frame_len,   n_frame_len;
    logic [POS_W-1:0] r_pos,         n_pos;
    logic [31:0]      w_len;
    logic             w_last;

    assign i_cfg.ready   = 1'b1;
    assign i_pixel.ready = !i_full;
    assign o_push        = i_pixel.valid && !i_full;

    always_comb begin
        w_len = 32'(r_frame_len);
        if (w_len == 32'd0) begin
            w_len = 32'd1;
        end else if (w_len > 32'(MAX_PIXELS)) begin
            w_len = 32'(MAX_PIXELS);
        end
        w_last = (32'(r_pos) + 32'd1) >= w_len;

        o_job.ch0  = r_grb_first ? i_pixel.green : i_pixel.red;
        o_job.ch1  = r_grb_first ? i_pixel.red   : i_pixel.green;
        o_job.ch2  = i_pixel.blue;
        o_job.pre  = (r_pos == '0);
        o_job.post = w_last;

        n_pos = r_pos;
        if (o_push) begin
            n_pos = w_last ? '0 : r_pos + POS_W'(1);
        end

        n_grb_first = r_grb_first;
        n_frame_len = r_frame_len;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_CHAN_ORDER:       n_grb_first = i_cfg.data[0];
                REG_PIXELS_PER_FRAME: n_frame_len = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grb_first <= 1'b1;
            r_frame_len <= LEN_W'(1);
            r_pos       <= '0;
        end else begin
            r_grb_first <= n_grb_first;
            r_frame_len <= n_frame_len;
            r_pos       <= n_pos;
        end
    end

endmodule

// ----- rtl/core/lpse_queue.sv -----
// ----------------------------------------------------------------------------
// LED pulse SPI symbol encoder job queue
// Short FIFO of pixel jobs between front end and serializer.
// ----------------------------------------------------------------------------
module lpse_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpse_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lpse_pkg::t_job  o_job
);
    import lpse_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_cnt, n_cnt;
    logic              w_push, w_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        w_push = i_push && !o_full;
        w_pop  = i_pop && o_valid;
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_cnt  = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr + QPTR_W'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd + QPTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + (QPTR_W+1)'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/lpse_back.sv -----
// ----------------------------------------------------------------------------
// LED pulse SPI symbol encoder serializer
// Emits guard and symbol bytes of the head job, one word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module lpse_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lpse_pkg::t_job  i_job,
    output logic            o_pop,
    lpse_byte_if.source     o_byte
);
    import lpse_pkg::*;

    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_ovalid, n_ovalid;
    logic [7:0]         r_obyte;
    logic               r_olast;
    logic               r_oend;
    logic [STEP_W-1:0]  w_off;
    logic [STEP_W-1:0]  w_end;
    logic [STEP_W-1:0]  w_d;
    logic               w_in_data;
    logic               w_fire;
    logic               w_done;
    logic [COLOR_W-1:0] w_ch;
    logic [2:0]         w_bi;
    logic [7:0]         w_byte;

    assign o_byte.valid         = r_ovalid;
    assign o_byte.out_byte      = r_obyte;
    assign o_byte.last_of_pixel = r_olast;
    assign o_byte.frame_end     = r_oend;

    always_comb begin
        w_off     = i_job.pre ? STEP_W'(PRE_GUARD) : '0;
        w_end     = w_off + STEP_W'(DATA_BYTES - 1)
                  + (i_job.post ? STEP_W'(POST_GUARD) : '0);
        w_d       = r_step - w_off;
        w_in_data = (r_step >= w_off) && (w_d < STEP_W'(DATA_BYTES));

        if (w_d < STEP_W'(BYTES_PER_CHANNEL)) begin
            w_ch = i_job.ch0;
            w_bi = w_d[2:0];
        end else if (w_d < STEP_W'(2*BYTES_PER_CHANNEL)) begin
            w_ch = i_job.ch1;
            w_bi = 3'(w_d - STEP_W'(BYTES_PER_CHANNEL));
        end else begin
            w_ch = i_job.ch2;
            w_bi = 3'(w_d - STEP_W'(2*BYTES_PER_CHANNEL));
        end
        w_byte = w_in_data ? sym_byte(w_ch, w_bi) : 8'h00;

        w_fire = i_valid && (!r_ovalid || o_byte.ready);
        w_done = (r_step == w_end);
        o_pop  = w_fire && w_done;

        n_step   = r_step;
        n_ovalid = r_ovalid;
        if (w_fire) begin
            n_step   = w_done ? '0 : r_step + STEP_W'(1);
            n_ovalid = 1'b1;
        end else if (o_byte.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_obyte <= w_byte;
            r_olast <= w_done;
            r_oend  <= w_done && i_job.post;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
